@@ rtl/kecd_pkg.sv @@
// Package of the keyed exclusion change detector.
// Holds the beat payload types, table entry type, event kinds and the
// command and status groups shared by the controller and the datapath.
package kecd_pkg;

	localparam logic [1:0] KIND_ENTERED = 2'd0;
	localparam logic [1:0] KIND_CHANGED = 2'd1;
	localparam logic [1:0] KIND_EXITED  = 2'd2;

	typedef struct packed {
		logic [63:0] target_key;
		logic        cycle_done;
		logic        is_excluded;
		logic [15:0] code_number;
		logic [3:0]  cause_number;
		logic [31:0] cycle_number;
		logic [9:0]  target_position;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  event_kind;
		logic [63:0] event_target;
		logic [31:0] event_cycle;
		logic [9:0]  event_position;
		logic [15:0] old_code;
		logic [3:0]  old_cause;
		logic [15:0] new_code;
		logic [3:0]  new_cause;
		logic        table_full;
	} out_item_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] key;
		logic [15:0] code;
		logic [3:0]  cause;
	} entry_t;

	typedef struct packed {
		logic start;
		logic clear;
		logic scan;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic ignore;
		logic clear_done;
		logic scan_done;
		logic out_free;
	} sts_t;

endpackage

@@ rtl/kecd_if.sv @@
// Valid/ready channel interfaces for the input records and the events.
// Depends on kecd_pkg for the beat payload types.
interface kecd_item_if;
	import kecd_pkg::*;
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface kecd_event_if;
	import kecd_pkg::*;
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/keyed_exclusion_change_detector.sv @@
// An accepted record is registered, then the table is read slot by slot, one read a cycle,
// until the key is found or the last slot has been read; the event is then registered in the
// decide state once the event side is free. A new record is taken only after the last one is
// decided, so any wait for a held event to be taken holds the input; while the detector is
// idle, ignored records are taken every cycle. Reset clears control state at once and then a
// clearing pass over every slot empties the table, during which no record is accepted.
module keyed_exclusion_change_detector #(
	parameter int ENTRIES = 64
) (
	input logic          clk,
	input logic          arst_n,
	kecd_item_if.sink    items,
	kecd_event_if.source events
);
	import kecd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	kecd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kecd_dp #(
		.ENTRIES (ENTRIES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_data (items.data),
		.cmd     (cmd),
		.sts     (sts),
		.events  (events)
	);

	assign items.ready = in_ready;

endmodule

@@ rtl/kecd_ctrl.sv @@
// Controller of the keyed exclusion change detector: clear, idle, scan and
// decide states. Depends on kecd_pkg for the command and status groups.
module kecd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  kecd_pkg::sts_t sts,
	output kecd_pkg::cmd_t cmd
);
	import kecd_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR  = 4'b0001,
		ST_IDLE   = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_ready && in_valid;

	always_comb begin
		cmd        = '0;
		cmd.start  = accept && !sts.ignore;
		cmd.clear  = (state_q == ST_CLEAR);
		cmd.scan   = (state_q == ST_SCAN);
		cmd.commit = (state_q == ST_DECIDE) && sts.out_free;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd.start) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (sts.scan_done) begin
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> sts.out_free)
		else $error("Event committed while the output register was occupied.");

	a_start_enters_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_SCAN)
		else $error("Accepted record did not start a table scan.");

	a_commit_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (state_q == ST_IDLE) && in_ready)
		else $error("Controller did not return to idle after a commit.");

endmodule

@@ rtl/kecd_dp.sv @@
// Datapath of the keyed exclusion change detector: record register, table
// memory with its scan pointer, match and free-slot tracking, and the event
// output register. Depends on kecd_pkg and kecd_event_if.
module kecd_dp #(
	parameter int ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  kecd_pkg::in_item_t in_data,
	input  kecd_pkg::cmd_t     cmd,
	output kecd_pkg::sts_t     sts,
	kecd_event_if.source       events
);
	import kecd_pkg::*;

	localparam int AW = $clog2(ENTRIES);
	localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

	entry_t    mem [ENTRIES];
	in_item_t  item_q;
	logic [AW-1:0] ptr_q;
	logic      rd_end_q;
	logic      rv_s1;
	logic [AW-1:0] idx_s1;
	entry_t    rd_s1;
	logic      hit_q;
	logic [AW-1:0] hit_idx_q;
	logic [15:0] hit_code_q;
	logic [3:0]  hit_cause_q;
	logic      free_q;
	logic [AW-1:0] free_idx_q;
	logic      ev_valid_q;
	out_item_t ev_q;

	logic      re;
	logic      match_now;
	logic      free_now;
	logic      same;
	logic      act_event;
	logic      act_write;
	logic [AW-1:0] act_idx;
	entry_t    act_entry;
	out_item_t act_out;
	logic      we;
	logic [AW-1:0] wa;
	entry_t    wd;

	assign re        = cmd.scan && !rd_end_q;
	assign match_now = rv_s1 && rd_s1.valid && (rd_s1.key == item_q.target_key);
	assign free_now  = rv_s1 && !rd_s1.valid;

	always_comb begin
		sts            = '0;
		sts.ignore     = !in_data.cycle_done || (in_data.target_key == 64'd0);
		sts.clear_done = (ptr_q == LAST);
		sts.scan_done  = rv_s1 && (match_now || (idx_s1 == LAST));
		sts.out_free   = !ev_valid_q || events.ready;
	end

	assign same = (hit_code_q == item_q.code_number) && (hit_cause_q == item_q.cause_number);

	always_comb begin
		act_event       = 1'b0;
		act_write       = 1'b0;
		act_idx         = hit_idx_q;
		act_entry       = '0;
		act_entry.key   = item_q.target_key;
		act_out         = '0;
		act_out.event_target   = item_q.target_key;
		act_out.event_cycle    = item_q.cycle_number;
		act_out.event_position = item_q.target_position;
		if (item_q.is_excluded && !hit_q) begin
			act_event               = 1'b1;
			act_write               = free_q;
			act_idx                 = free_idx_q;
			act_entry.valid         = 1'b1;
			act_entry.code          = item_q.code_number;
			act_entry.cause         = item_q.cause_number;
			act_out.event_kind      = KIND_ENTERED;
			act_out.new_code        = item_q.code_number;
			act_out.new_cause       = item_q.cause_number;
			act_out.table_full      = !free_q;
		end else if (item_q.is_excluded) begin
			act_event               = !same;
			act_write               = !same;
			act_entry.valid         = 1'b1;
			act_entry.code          = item_q.code_number;
			act_entry.cause         = item_q.cause_number;
			act_out.event_kind      = KIND_CHANGED;
			act_out.old_code        = hit_code_q;
			act_out.old_cause       = hit_cause_q;
			act_out.new_code        = item_q.code_number;
			act_out.new_cause       = item_q.cause_number;
		end else if (hit_q) begin
			act_event               = 1'b1;
			act_write               = 1'b1;
			act_out.event_kind      = KIND_EXITED;
			act_out.old_code        = hit_code_q;
			act_out.old_cause       = hit_cause_q;
		end
	end

	assign we = cmd.clear || (cmd.commit && act_write);
	assign wa = cmd.clear ? ptr_q : act_idx;
	assign wd = cmd.clear ? entry_t'('0) : act_entry;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_s1 <= mem[ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			item_q <= in_data;
		end
		idx_s1 <= ptr_q;
		if (cmd.scan && match_now && !hit_q) begin
			hit_idx_q   <= idx_s1;
			hit_code_q  <= rd_s1.code;
			hit_cause_q <= rd_s1.cause;
		end
		if (cmd.scan && free_now && !free_q) begin
			free_idx_q <= idx_s1;
		end
		if (cmd.commit && act_event) begin
			ev_q <= act_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			rd_end_q   <= 1'b0;
			rv_s1      <= 1'b0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
			ev_valid_q <= 1'b0;
		end else begin
			rv_s1 <= re;
			if (cmd.start) begin
				ptr_q    <= '0;
				rd_end_q <= 1'b0;
				hit_q    <= 1'b0;
				free_q   <= 1'b0;
			end else begin
				if (cmd.clear) begin
					ptr_q <= ptr_q + AW'(1);
				end else if (re) begin
					ptr_q    <= (ptr_q == LAST) ? ptr_q : ptr_q + AW'(1);
					rd_end_q <= (ptr_q == LAST);
				end
				if (cmd.scan && match_now) begin
					hit_q <= 1'b1;
				end
				if (cmd.scan && free_now) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.commit && act_event) begin
				ev_valid_q <= 1'b1;
			end else if (events.ready) begin
				ev_valid_q <= 1'b0;
			end
		end
	end

	assign events.valid = ev_valid_q;
	assign events.data  = ev_q;

endmodule
